FILE: sv/mcb_pkg.sv
// Shared types and constants for the March C- memory self-test controller.
// Depends on nothing; imported by mcb_core and march_c_minus_bist.
package mcb_pkg;

  // Field widths of the request and result streams
  localparam int CFG_W      = 18;
  localparam int ADDR_W     = 17;
  localparam int DATA_W     = 64;
  localparam int BYTE_ADR_W = 20;

  // Run phase: idle, or one of the six march elements
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_E0   = 3'd1;

  // March elements
  localparam logic [2:0] EL_0 = 3'd0;
  localparam logic [2:0] EL_1 = 3'd1;
  localparam logic [2:0] EL_2 = 3'd2;
  localparam logic [2:0] EL_3 = 3'd3;
  localparam logic [2:0] EL_4 = 3'd4;
  localparam logic [2:0] EL_5 = 3'd5;

  // Fault kinds
  localparam logic [1:0] FK_NONE = 2'd0;
  localparam logic [1:0] FK_SA0  = 2'd1;
  localparam logic [1:0] FK_SA1  = 2'd2;
  localparam logic [1:0] FK_TRAN = 2'd3;

  typedef struct packed {
    logic                  cmd_valid;
    logic                  cmd_write;
    logic [ADDR_W-1:0]     cmd_addr;
    logic [DATA_W-1:0]     cmd_wdata;
    logic                  busy;
    logic                  done;
    logic                  failed;
    logic [1:0]            fault_kind;
    logic [2:0]            fail_element;
    logic [BYTE_ADR_W-1:0] fail_byte_addr;
  } result_t;

  // Fault kind reported by a read mismatch in a given element
  function automatic logic [1:0] fault_of(input logic [2:0] elem);
    logic [1:0] k;
    case (elem)
      EL_1:    k = FK_SA1;
      EL_2:    k = FK_SA0;
      EL_3:    k = FK_TRAN;
      EL_4:    k = FK_SA0;
      EL_5:    k = FK_SA1;
      default: k = FK_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/mcb_core.sv
// March C- sequencer: run state, per-cycle command and fault check.
// Depends on mcb_pkg; one request is processed per cycle when step is high.
module mcb_core #(
  parameter int ADDR_BITS = 17,
  parameter int WORD_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         start_req,
  input  logic [mcb_pkg::DATA_W-1:0]   read_data,
  input  logic [mcb_pkg::CFG_W-1:0]    word_count,
  output mcb_pkg::result_t             res
);
  import mcb_pkg::*;

  localparam int WORD_BYTES = WORD_BITS / 8;
  localparam int CLAMP = (ADDR_BITS >= CFG_W) ? ((1 << CFG_W) - 1) : (1 << ADDR_BITS);
  localparam logic [CFG_W-1:0] CNT_MAX = CLAMP[CFG_W-1:0];
  localparam logic [CFG_W-1:0] IDX_MASK =
    (ADDR_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((1 << ADDR_BITS) - 1);
  localparam logic [DATA_W-1:0] DATA_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

  logic [2:0]       phase, phase_next;
  logic [CFG_W-1:0] word_index, idx_next;
  logic             read_pending, rp_next;
  logic             done_flag, done_next;
  logic [1:0]       fault_code, fc_next;
  logic [2:0]       fault_element, fe_next;
  logic [CFG_W-1:0] fault_index, fi_next;
  logic [CFG_W-1:0] run_count, run_next;

  logic [CFG_W-1:0] clamped;
  logic [2:0]       elem, nxt_elem;
  logic             desc, nxt_desc, at_end, do_adv;
  logic [CFG_W:0]   idx_inc;
  logic [CFG_W-1:0] idx_cur;
  logic [DATA_W-1:0] exp_data, rdata_m;

  assign clamped = (word_count > CNT_MAX) ? CNT_MAX : word_count;
  assign rdata_m = read_data & DATA_MASK;

  always_comb begin
    phase_next = phase;
    idx_next   = word_index;
    rp_next    = read_pending;
    done_next  = done_flag;
    fc_next    = fault_code;
    fe_next    = fault_element;
    fi_next    = fault_index;
    run_next   = run_count;
    res        = '0;
    do_adv     = 1'b0;

    // Start from idle: clear the record, latch the word count
    if (phase == PH_IDLE && start_req) begin
      done_next = 1'b0;
      fc_next   = FK_NONE;
      fe_next   = EL_0;
      fi_next   = '0;
      run_next  = clamped;
      if (clamped == '0) begin
        done_next = 1'b1;
      end else begin
        phase_next = PH_E0;
        idx_next   = '0;
        rp_next    = 1'b0;
      end
    end

    elem     = phase_next - PH_E0;
    nxt_elem = elem + 3'd1;
    desc     = elem inside {EL_3, EL_4};
    nxt_desc = nxt_elem inside {EL_3, EL_4};
    idx_cur  = idx_next & IDX_MASK;
    idx_inc  = {1'b0, idx_next} + {{CFG_W{1'b0}}, 1'b1};
    at_end   = desc ? (idx_next == '0) : (idx_inc >= {1'b0, run_next});
    exp_data = (elem inside {EL_2, EL_4}) ? DATA_MASK : '0;

    if (phase_next != PH_IDLE) begin
      if (elem == EL_0) begin
        res.cmd_valid = 1'b1;
        res.cmd_write = 1'b1;
        res.cmd_addr  = idx_cur[ADDR_W-1:0];
        do_adv        = 1'b1;
      end else if (!rp_next) begin
        res.cmd_valid = 1'b1;
        res.cmd_addr  = idx_cur[ADDR_W-1:0];
        rp_next       = 1'b1;
      end else if (rdata_m != exp_data) begin
        // First mismatch: record it and stop
        fc_next    = fault_of(elem);
        fe_next    = elem;
        fi_next    = idx_cur;
        phase_next = PH_IDLE;
        rp_next    = 1'b0;
        done_next  = 1'b1;
      end else begin
        rp_next = 1'b0;
        if (elem != EL_5) begin
          res.cmd_valid = 1'b1;
          res.cmd_write = 1'b1;
          res.cmd_addr  = idx_cur[ADDR_W-1:0];
          res.cmd_wdata = exp_data ^ DATA_MASK;
        end
        do_adv = 1'b1;
      end
    end

    // Next word, or next element at the end of this one
    if (do_adv) begin
      if (at_end) begin
        rp_next = 1'b0;
        if (elem == EL_5) begin
          phase_next = PH_IDLE;
          done_next  = 1'b1;
          idx_next   = '0;
        end else begin
          phase_next = phase_next + 3'd1;
          idx_next   = nxt_desc ? (run_next - {{(CFG_W-1){1'b0}}, 1'b1}) : '0;
        end
      end else if (desc) begin
        idx_next = idx_next - {{(CFG_W-1){1'b0}}, 1'b1};
      end else begin
        idx_next = idx_inc[CFG_W-1:0];
      end
    end

    res.busy           = (phase_next != PH_IDLE);
    res.done           = done_next;
    res.failed         = done_next && (fc_next != FK_NONE);
    res.fault_kind     = fc_next;
    res.fail_element   = fe_next;
    res.fail_byte_addr = (fc_next != FK_NONE) ? BYTE_ADR_W'(fi_next * WORD_BYTES) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      word_index    <= '0;
      read_pending  <= 1'b0;
      done_flag     <= 1'b0;
      fault_code    <= FK_NONE;
      fault_element <= EL_0;
      fault_index   <= '0;
      run_count     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      word_index    <= idx_next;
      read_pending  <= rp_next;
      done_flag     <= done_next;
      fault_code    <= fc_next;
      fault_element <= fe_next;
      fault_index   <= fi_next;
      run_count     <= run_next;
    end
  end

  a_run_not_done: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> !done_flag)
    else $error("done flag set while a test is running");

  a_read_in_rw_elem: assert property (@(posedge clk) disable iff (rst)
    read_pending |-> (phase != PH_IDLE && phase != PH_E0))
    else $error("read pending outside a read element");

  a_fault_means_done: assert property (@(posedge clk) disable iff (rst)
    (fault_code != FK_NONE) |-> done_flag)
    else $error("fault recorded without a finished test");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (word_index < run_count))
    else $error("word index beyond latched word count");

endmodule

FILE: sv/march_c_minus_bist.sv
// Top level of the March C- memory self-test controller.
// Depends on mcb_pkg and mcb_core; holds the request and result registers.
//
// One request on the slave stream stands for one memory cycle: it carries a
// start flag and the data the SRAM returned for the previous cycle's read.
// Each request yields exactly one result on the master stream with the
// memory command for that cycle (read or write, word address, all-zeros or
// all-ones data) and the test status (busy, done, failed, fault kind,
// failing element and byte address). The controller takes one request every
// clock cycle while the result slot is free or drains downstream; a result
// is offered on the master stream once its request has been accepted into
// the request register and the sequencer step has loaded the result
// register. The rate is set by the sequencer step between the two registers.
// The request register can take a new request while a finished result still
// waits for the downstream side. The sequencer latches the word count at
// start, clamped to 2^ADDR_BITS words; a count of zero passes at once.
module march_c_minus_bist #(
  parameter int ADDR_BITS = 17,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mcb_pkg::CFG_W-1:0]   cfg_wr_data,   // word_count
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [71:0]                 s_axis_tdata,  // start_req, read_data[63:0], pad
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [111:0]                m_axis_tdata   // cmd_valid, cmd_write, cmd_addr[16:0],
                                                     // cmd_wdata[63:0], busy_res, done_res,
                                                     // failed, fault_kind[1:0],
                                                     // fail_element[2:0], fail_byte_addr[19:0],
                                                     // pad
);
  import mcb_pkg::*;

  localparam logic [CFG_W-1:0] WC_RESET = CFG_W'(131072);

  logic [CFG_W-1:0]  word_count;
  logic              in_valid;
  logic              in_start;
  logic [DATA_W-1:0] in_rdata;
  logic              step;
  result_t           res;

  // Advance when a request is held and the result slot is free or draining
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= WC_RESET;
    end else if (cfg_wr_en) begin
      word_count <= cfg_wr_data;
    end
  end

  // Request register: hold the request until the sequencer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start <= s_axis_tdata[0];
      in_rdata <= s_axis_tdata[DATA_W:1];
    end
  end

  mcb_core #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_req  (in_start),
    .read_data  (in_rdata),
    .word_count (word_count),
    .res        (res)
  );

  // Result register: load on each step, drop once taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {1'b0,
                       res.fail_byte_addr,
                       res.fail_element,
                       res.fault_kind,
                       res.failed,
                       res.done,
                       res.busy,
                       res.cmd_wdata,
                       res.cmd_addr,
                       res.cmd_write,
                       res.cmd_valid};
    end
  end

endmodule
